/* design/sta_pkg.sv */
// Package for the super-twisting attitude axis controller.
// Shared widths, register indexes and the datapath command/status types. No dependencies.
package sta_pkg;
    localparam int FracBits = 16;
    localparam int CfgW     = 31;
    localparam int DataW    = 32;
    localparam int DtW      = 17;
    localparam int CfgIdxW  = 3;

    localparam logic [CfgIdxW-1:0] REG_GAIN_C    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ALPHA     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_LAMBDA    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_NORM_MIN  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_NORM_MAX  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_INERTIA   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_INT_LIMIT = 3'd6;

    // 400 deg in rad with 32 fraction bits; KConst rounds it to FracBits fraction bits
    localparam longint Rad400Q32 = 64'sd29984528232;
    localparam longint KConst =
        (Rad400Q32 + (64'sd1 <<< (31 - FracBits))) >>> (32 - FracBits);

    // (|ita| << 16) / KConst == (|ita| * QRecip) >> 34, exact for |ita| < 2^19;
    // at or above that q*q already drives the anti-windup factor to zero
    localparam logic [31:0]        QRecip = 32'd2460832795;
    localparam logic signed [31:0] QBig   = 32'sd1048576;

    // datapath step codes
    typedef enum logic [3:0] {
        OP_ITA, OP_NORM, OP_DIV_SGN, OP_DIV_Q, OP_SQRT, OP_PROD,
        OP_NONL, OP_TORQUE, OP_WDOT, OP_Q2, OP_FACTOR, OP_T1, OP_T2, OP_WUPD
    } t_op;

    typedef struct packed {
        logic start;   // start multi-cycle unit / one step
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic busy;    // multi-cycle unit still working
    } t_stat;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [127:0] x);
        if (x > 128'sd2147483647)       return 32'sh7fffffff;
        else if (x < -128'sd2147483648) return 32'sh80000000;
        else                            return x[DataW-1:0];
    endfunction
endpackage

/* design/sta_datapath.sv */
// Datapath: operand registers, shared multiplier, serial divider and square root.
// Depends on sta_pkg; driven by sta_ctrl through t_cmd/t_stat.
module sta_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sta_pkg::t_cmd                 i_cmd,
    output sta_pkg::t_stat                o_stat,
    input  logic                          i_load,
    input  logic signed [31:0]            i_attitude_err,
    input  logic signed [31:0]            i_rate_meas,
    input  logic signed [31:0]            i_rate_target,
    input  logic signed [31:0]            i_accel_meas,
    input  logic [16:0]                   i_step_time,
    input  logic                          i_on_ground,
    input  logic                          i_sat_high,
    input  logic                          i_sat_low,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [30:0]                   i_cfg_data,
    output logic                          o_landed,
    output logic signed [31:0]            o_torque,
    output logic signed [31:0]            o_sliding_value,
    output logic signed [31:0]            o_integral_rate,
    output logic signed [31:0]            o_integral_value
);
    import sta_pkg::*;

    logic [CfgW-1:0] r_c, r_alpha, r_lambda, r_nmin, r_nmax, r_inertia, r_lim;
    logic signed [31:0] r_err, r_rate, r_target, r_accel;
    logic [DtW-1:0] r_dt;
    logic r_landed, r_hi, r_lo;
    logic signed [31:0] r_w, r_ita, r_sgn, r_q, r_wdot, r_torque;
    logic signed [31:0] r_ic, r_damp, r_acc, r_nonl, r_t1, r_factor;
    logic [31:0] r_norm, r_root;

    // serial restoring divider (|num| / den), 48-bit numerator
    logic [47:0] r_dq;
    logic [47:0] r_drem;
    logic [31:0] r_dden;
    logic        r_dneg;
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    logic [48:0] n_drem;
    logic [47:0] dnum;
    logic signed [63:0] div_signed;

    // serial square root on 48-bit value
    logic [47:0] r_sv, r_sr, r_sb;
    logic        r_sbusy;

    logic signed [31:0] mag;

    // shared 33x33 signed multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] mul_sh;
    assign mul_p  = mul_a * mul_b;
    assign mul_sh = mul_p >>> FracBits;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_ITA:    begin mul_a = {2'b0, r_c};       mul_b = 33'(r_err); end
            OP_NORM:   begin mul_a = {2'b0, r_inertia}; mul_b = {2'b0, r_c}; end
            OP_DIV_SGN:begin mul_a = 33'(r_ic); mul_b = 33'(sat32(128'(r_rate) - 128'(r_target))); end
            OP_DIV_Q:  begin mul_a = {2'b0, r_inertia}; mul_b = 33'(r_accel); end
            OP_SQRT:   begin mul_a = {14'b0, mag[18:0]}; mul_b = {1'b0, QRecip}; end
            OP_PROD:   begin mul_a = {2'b0, r_alpha};   mul_b = {1'b0, r_root}; end
            OP_NONL:   begin mul_a = 33'(r_nonl);       mul_b = 33'(r_sgn); end
            OP_WDOT:   begin mul_a = {2'b0, r_lambda};  mul_b = 33'(r_sgn); end
            OP_Q2:     begin mul_a = 33'(r_q);          mul_b = 33'(r_q); end
            OP_T1:     begin mul_a = 33'(r_factor);     mul_b = 33'(r_wdot); end
            OP_T2, OP_WUPD: begin mul_a = 33'(r_t1);    mul_b = {16'b0, r_dt}; end
            default:   ;
        endcase
    end

    logic [31:0] n_norm;
    logic signed [63:0] ita_sh;
    logic signed [33:0] n_w;
    logic signed [33:0] lim_s;
    always_comb begin
        mag = r_ita[31] ? -r_ita : r_ita;
        if ({1'b0, mag} < {2'b0, r_nmin})      n_norm = {1'b0, r_nmin};
        else if ({1'b0, mag} > {2'b0, r_nmax}) n_norm = {1'b0, r_nmax};
        else                                   n_norm = mag;
        if (n_norm == '0) n_norm = 32'd1;
        ita_sh = 64'(r_ita) <<< FracBits;
        dnum   = ita_sh[63] ? 48'(-ita_sh) : 48'(ita_sh);
        n_drem = {r_drem[47:0], r_dq[47]};
        div_signed = r_dneg ? -64'(r_dq) : 64'(r_dq);
        n_w = 34'(r_w) + 34'(mul_sh);
        lim_s = 34'(r_lim);
    end

    assign o_stat.busy = r_dbusy | r_sbusy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= 31'd65536; r_alpha <= '0; r_lambda <= '0; r_nmin <= 31'd66;
            r_nmax <= 31'd655360; r_inertia <= 31'd65536; r_lim <= '0;
            r_w <= '0;
            r_dbusy <= 1'b0;
            r_sbusy <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN_C:    r_c <= i_cfg_data;
                    REG_ALPHA:     r_alpha <= i_cfg_data;
                    REG_LAMBDA:    r_lambda <= i_cfg_data;
                    REG_NORM_MIN:  r_nmin <= i_cfg_data;
                    REG_NORM_MAX:  r_nmax <= i_cfg_data;
                    REG_INERTIA:   r_inertia <= i_cfg_data;
                    REG_INT_LIMIT: r_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_load) begin
                r_err <= i_attitude_err; r_rate <= i_rate_meas;
                r_target <= i_rate_target; r_accel <= i_accel_meas;
                r_dt <= i_step_time; r_landed <= i_on_ground;
                r_hi <= i_sat_high; r_lo <= i_sat_low;
            end
            // divider runs one quotient bit a cycle
            if (r_dbusy) begin
                if (n_drem >= {17'b0, r_dden}) begin
                    r_drem <= 48'(n_drem - {17'b0, r_dden});
                    r_dq   <= {r_dq[46:0], 1'b1};
                end else begin
                    r_drem <= n_drem[47:0];
                    r_dq   <= {r_dq[46:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 6'd1;
                if (r_dcnt == 6'd1) r_dbusy <= 1'b0;
            end
            // square root: one result bit a cycle
            if (r_sbusy) begin
                if (r_sv >= r_sr + r_sb) begin
                    r_sv <= r_sv - (r_sr + r_sb);
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
                if (r_sb[1:0] != 2'b00 || r_sb == 48'd0) r_sbusy <= 1'b0;
            end
            if (i_cmd.start) begin
                case (i_cmd.op)
                    OP_ITA: r_ita <= sat32(128'(r_target) - 128'(r_rate) + 128'(mul_sh));
                    OP_NORM: begin
                        r_norm <= n_norm;
                        r_ic   <= sat32(128'(mul_sh));
                        r_dq <= dnum; r_drem <= '0; r_dden <= n_norm;
                        r_dneg <= r_ita[31]; r_dcnt <= 6'd48; r_dbusy <= 1'b1;
                    end
                    OP_DIV_SGN: begin
                        r_sgn  <= sat32(128'(div_signed));
                        r_damp <= sat32(128'(mul_sh));
                    end
                    OP_DIV_Q: begin
                        r_acc <= sat32(128'(mul_sh));
                        r_sv <= {r_norm, 16'b0}; r_sr <= '0;
                        r_sb <= 48'h4000_0000_0000 >> 0; r_sbusy <= 1'b1;
                    end
                    OP_SQRT: begin
                        r_root <= r_sr[31:0];
                        // only q*q is used, so the magnitude is enough
                        r_q <= (mag[31:19] != '0) ? QBig : 32'(mul_p >>> 34);
                    end
                    OP_PROD: r_nonl <= sat32(128'(mul_sh));
                    OP_NONL: r_nonl <= sat32(128'(mul_sh));
                    OP_TORQUE: r_torque <= sat32(128'(r_damp) + 128'(r_nonl)
                                                 + 128'(r_w) - 128'(r_acc));
                    OP_WDOT: r_wdot <= sat32(128'(mul_sh));
                    OP_Q2: begin
                        if (r_hi && !r_wdot[31] && r_wdot != 0) r_wdot <= '0;
                        if (r_lo && r_wdot[31])                 r_wdot <= '0;
                        r_factor <= (mul_sh > 66'sd65536) ? 32'sd0
                                                          : 32'(66'sd65536 - mul_sh);
                    end
                    OP_T1: r_t1 <= 32'(mul_sh);
                    OP_WUPD: begin
                        if (n_w < -lim_s)     r_w <= 32'(-lim_s);
                        else if (n_w > lim_s) r_w <= 32'(lim_s);
                        else                  r_w <= n_w[31:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_landed         = r_landed;
    assign o_torque         = r_torque;
    assign o_sliding_value  = r_ita;
    assign o_integral_rate  = r_wdot;
    assign o_integral_value = r_w;
endmodule

/* design/sta_ctrl.sv */
// Controller: sequences one control tick through the datapath steps.
// Depends on sta_pkg.
module sta_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  logic           i_landed,
    output logic           o_load,
    output sta_pkg::t_cmd  o_cmd,
    input  sta_pkg::t_stat i_stat
);
    import sta_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_OUT} t_state;
    t_state r_state;
    t_op    r_op;
    logic   r_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_load  = i_valid && o_ready;
    assign o_valid = r_valid;
    always_comb begin
        o_cmd.op    = r_op;
        o_cmd.start = (r_state == S_RUN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_ITA;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin r_state <= S_RUN; r_op <= OP_ITA; end
                S_RUN: begin
                    case (r_op)
                        OP_NORM, OP_DIV_Q: r_state <= S_WAIT;
                        OP_WDOT: if (i_landed) begin
                            r_state <= S_OUT; r_valid <= 1'b1;
                        end
                        OP_WUPD: begin r_state <= S_OUT; r_valid <= 1'b1; end
                        default: ;
                    endcase
                    if (r_op != OP_WUPD) r_op <= t_op'(r_op + 4'd1);
                end
                S_WAIT: if (!i_stat.busy) r_state <= S_RUN;
                S_OUT: if (i_ready) begin r_valid <= 1'b0; r_state <= S_IDLE; end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_OUT) else $error("valid outside output state");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT && i_stat.busy |=> !o_cmd.start) else $error("start while busy");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> !o_ready) else $error("second item taken");
endmodule

/* design/super_twisting_attitude_axis.sv */
// Top level of the super-twisting attitude axis controller.
// Depends on sta_pkg, sta_ctrl and sta_datapath.
//  channel | handshake            | payload
//  in      | i_valid / o_ready    | attitude_err .. sat_low
//  out     | o_valid / i_ready    | torque, sliding_value, integral_rate, integral_value
//  cfg     | i_cfg_we             | i_cfg_idx, i_cfg_data
// The length of one tick from accept to accept is set by the 48-step serial divide
// and the 24-step square root; a landed tick ends after the integral rate step.
// One item at a time; reset is synchronous, clears the integral and loads the
// configuration defaults; a stalled result holds and keeps the input closed.
module super_twisting_attitude_axis (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_attitude_err,
    input  logic signed [31:0] i_rate_meas,
    input  logic signed [31:0] i_rate_target,
    input  logic signed [31:0] i_accel_meas,
    input  logic [16:0]        i_step_time,
    input  logic               i_on_ground,
    input  logic               i_sat_high,
    input  logic               i_sat_low,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_torque,
    output logic signed [31:0] o_sliding_value,
    output logic signed [31:0] o_integral_rate,
    output logic signed [31:0] o_integral_value,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);
    import sta_pkg::*;
    t_cmd  cmd;
    t_stat stat;
    logic  load, landed;

    sta_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_landed(landed), .o_load(load), .o_cmd(cmd), .i_stat(stat)
    );
    sta_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_load(load),
        .i_attitude_err, .i_rate_meas, .i_rate_target, .i_accel_meas,
        .i_step_time, .i_on_ground, .i_sat_high, .i_sat_low,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_landed(landed),
        .o_torque, .o_sliding_value, .o_integral_rate, .o_integral_value
    );
endmodule
